// File: hdl/ifp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_pkg: shared types and constants of the fix record parser
// Character codes, byte positions of the record, field lookup table,
// the queued record format and the arithmetic helpers.
// ----------------------------------------------------------------------------
package ifp_pkg;

    // Numeric fields of a fix record, in line order
    typedef enum logic [2:0] {
        FLD_HOURS,
        FLD_MINUTES,
        FLD_SECONDS,
        FLD_LAT_DEG,
        FLD_LAT_MIN,
        FLD_LON_DEG,
        FLD_LON_MIN,
        FLD_ALT
    } field_t;

    localparam int NUM_FIELDS = 8;

    // ASCII codes
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // Byte positions of the single-character items
    localparam logic [5:0] POS_FIX      = 6'd0;
    localparam logic [5:0] POS_NS       = 6'd14;
    localparam logic [5:0] POS_EW       = 6'd23;
    localparam logic [5:0] POS_ALT_FLAG = 6'd24;
    localparam logic [5:0] POS_MAX      = 6'd63;

    // Arithmetic constants
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [15:0] UNITS_PER_DEG = 16'd60000;

    // Decoupling queue between parser and result builder
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Which field a byte position belongs to
    typedef struct packed {
        logic   hit;
        field_t idx;
        logic   first;
    } field_sel_t;

    // One parsed line, signed field values already resolved
    typedef struct packed {
        logic               fix;
        logic               north;
        logic               east;
        logic               alt_flag;
        logic signed [7:0]  hours;
        logic signed [7:0]  minutes;
        logic signed [7:0]  seconds;
        logic signed [7:0]  lat_deg;
        logic signed [17:0] lat_min;
        logic signed [10:0] lon_deg;
        logic signed [17:0] lon_min;
        logic signed [17:0] alt;
    } ifp_rec_t;

    // Fixed-position field map of a fix record
    function automatic field_sel_t field_lookup(logic [5:0] pos);
        field_sel_t s;
        s = '{hit: 1'b0, idx: FLD_HOURS, first: 1'b0};
        case (pos)
            6'd1:  s = '{hit: 1'b1, idx: FLD_HOURS,   first: 1'b1};
            6'd2:  s = '{hit: 1'b1, idx: FLD_HOURS,   first: 1'b0};
            6'd3:  s = '{hit: 1'b1, idx: FLD_MINUTES, first: 1'b1};
            6'd4:  s = '{hit: 1'b1, idx: FLD_MINUTES, first: 1'b0};
            6'd5:  s = '{hit: 1'b1, idx: FLD_SECONDS, first: 1'b1};
            6'd6:  s = '{hit: 1'b1, idx: FLD_SECONDS, first: 1'b0};
            6'd7:  s = '{hit: 1'b1, idx: FLD_LAT_DEG, first: 1'b1};
            6'd8:  s = '{hit: 1'b1, idx: FLD_LAT_DEG, first: 1'b0};
            6'd9:  s = '{hit: 1'b1, idx: FLD_LAT_MIN, first: 1'b1};
            6'd10, 6'd11, 6'd12, 6'd13:
                   s = '{hit: 1'b1, idx: FLD_LAT_MIN, first: 1'b0};
            6'd15: s = '{hit: 1'b1, idx: FLD_LON_DEG, first: 1'b1};
            6'd16, 6'd17:
                   s = '{hit: 1'b1, idx: FLD_LON_DEG, first: 1'b0};
            6'd18: s = '{hit: 1'b1, idx: FLD_LON_MIN, first: 1'b1};
            6'd19, 6'd20, 6'd21, 6'd22:
                   s = '{hit: 1'b1, idx: FLD_LON_MIN, first: 1'b0};
            6'd25: s = '{hit: 1'b1, idx: FLD_ALT,     first: 1'b1};
            6'd26, 6'd27, 6'd28, 6'd29:
                   s = '{hit: 1'b1, idx: FLD_ALT,     first: 1'b0};
            default: s = '{hit: 1'b0, idx: FLD_HOURS, first: 1'b0};
        endcase
        return s;
    endfunction

    // Decimal digit accumulate: a*10 + d
    function automatic logic [16:0] mul10_add(logic [16:0] a, logic [3:0] d);
        logic [20:0] w;
        w = {4'b0, a};
        return 17'((w << 3) + (w << 1) + 21'(d));
    endfunction

    // Field value: zero when a bad character was seen, negated on leading minus
    function automatic logic signed [17:0] field_val(logic [16:0] acc, logic inv,
                                                     logic neg);
        logic signed [17:0] v;
        v = $signed({1'b0, acc});
        if (inv)
            return '0;
        return neg ? -v : v;
    endfunction

endpackage

// File: hdl/ifp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_front: byte parser
// Takes one byte per transfer, classifies it by position and accumulates
// the numeric fields; on the last byte of a line pushes one record.
// ----------------------------------------------------------------------------
module ifp_front
    import ifp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] char_code,
    input  logic       end_of_line,
    input  logic       q_full,
    output logic       in_stall,
    output logic       push,
    output ifp_rec_t   rec
);

    typedef struct packed {
        logic [5:0]  pos;
        logic        fix;
        logic        north;
        logic        east;
        logic        alt_flag;
        logic [6:0]  hours;
        logic [6:0]  minutes;
        logic [6:0]  seconds;
        logic [6:0]  lat_deg;
        logic [16:0] lat_min;
        logic [9:0]  lon_deg;
        logic [16:0] lon_min;
        logic [16:0] alt;
        logic [7:0]  inv;
        logic [7:0]  neg;
    } line_t;

    line_t      line_reg;
    line_t      line_next;
    line_t      line_upd;
    field_sel_t sel;
    logic       accept;
    logic       is_digit;
    logic [3:0] digit;
    logic [16:0] acc_old;
    logic [16:0] acc_new;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept && end_of_line;

    // Byte classification
    assign sel      = field_lookup(line_reg.pos);
    assign is_digit = (char_code >= CH_0) && (char_code <= CH_9);
    assign digit    = 4'(char_code - CH_0);

    // Accumulator of the field this byte belongs to
    always_comb
    begin
        case (sel.idx)
            FLD_HOURS:   acc_old = 17'(line_reg.hours);
            FLD_MINUTES: acc_old = 17'(line_reg.minutes);
            FLD_SECONDS: acc_old = 17'(line_reg.seconds);
            FLD_LAT_DEG: acc_old = 17'(line_reg.lat_deg);
            FLD_LAT_MIN: acc_old = line_reg.lat_min;
            FLD_LON_DEG: acc_old = 17'(line_reg.lon_deg);
            FLD_LON_MIN: acc_old = line_reg.lon_min;
            FLD_ALT:     acc_old = line_reg.alt;
            default:     acc_old = '0;
        endcase
    end

    assign acc_new = mul10_add(acc_old, digit);

    // Line state including the current byte
    always_comb
    begin
        line_upd = line_reg;
        case (line_reg.pos)
            POS_FIX:      line_upd.fix      = (char_code == CH_B);
            POS_NS:       line_upd.north    = (char_code == CH_N);
            POS_EW:       line_upd.east     = (char_code == CH_E);
            POS_ALT_FLAG: line_upd.alt_flag = (char_code == CH_A);
            default:
            begin
                if (sel.hit)
                begin
                    if (sel.first && (char_code == CH_MINUS))
                        line_upd.neg[sel.idx] = 1'b1;
                    else if (is_digit)
                    begin
                        case (sel.idx)
                            FLD_HOURS:   line_upd.hours   = 7'(acc_new);
                            FLD_MINUTES: line_upd.minutes = 7'(acc_new);
                            FLD_SECONDS: line_upd.seconds = 7'(acc_new);
                            FLD_LAT_DEG: line_upd.lat_deg = 7'(acc_new);
                            FLD_LAT_MIN: line_upd.lat_min = acc_new;
                            FLD_LON_DEG: line_upd.lon_deg = 10'(acc_new);
                            FLD_LON_MIN: line_upd.lon_min = acc_new;
                            FLD_ALT:     line_upd.alt     = acc_new;
                            default:     line_upd.alt     = line_reg.alt;
                        endcase
                    end
                    else
                        line_upd.inv[sel.idx] = 1'b1;
                end
            end
        endcase
        if (line_reg.pos != POS_MAX)
            line_upd.pos = line_reg.pos + 6'd1;
    end

    // Clear per-line state after the last byte
    always_comb
    begin
        line_next = line_reg;
        if (accept)
            line_next = end_of_line ? '0 : line_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_reg <= '0;
        else
            line_reg <= line_next;
    end

    // Record handed to the queue
    always_comb
    begin
        rec.fix      = line_upd.fix;
        rec.north    = line_upd.north;
        rec.east     = line_upd.east;
        rec.alt_flag = line_upd.alt_flag;
        rec.hours    = 8'(field_val(17'(line_upd.hours), line_upd.inv[FLD_HOURS],
                                    line_upd.neg[FLD_HOURS]));
        rec.minutes  = 8'(field_val(17'(line_upd.minutes), line_upd.inv[FLD_MINUTES],
                                    line_upd.neg[FLD_MINUTES]));
        rec.seconds  = 8'(field_val(17'(line_upd.seconds), line_upd.inv[FLD_SECONDS],
                                    line_upd.neg[FLD_SECONDS]));
        rec.lat_deg  = 8'(field_val(17'(line_upd.lat_deg), line_upd.inv[FLD_LAT_DEG],
                                    line_upd.neg[FLD_LAT_DEG]));
        rec.lat_min  = field_val(line_upd.lat_min, line_upd.inv[FLD_LAT_MIN],
                                 line_upd.neg[FLD_LAT_MIN]);
        rec.lon_deg  = 11'(field_val(17'(line_upd.lon_deg), line_upd.inv[FLD_LON_DEG],
                                     line_upd.neg[FLD_LON_DEG]));
        rec.lon_min  = field_val(line_upd.lon_min, line_upd.inv[FLD_LON_MIN],
                                 line_upd.neg[FLD_LON_MIN]);
        rec.alt      = field_val(line_upd.alt, line_upd.inv[FLD_ALT],
                                 line_upd.neg[FLD_ALT]);
    end

    // Position restarts after every line
    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> line_reg.pos == 6'd0)
        else $error("byte position not cleared after end of line");

    // Position counts bytes within a line
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !end_of_line && (line_reg.pos != POS_MAX)
        |=> line_reg.pos == $past(line_reg.pos) + 6'd1)
        else $error("byte position did not advance");

endmodule

// File: hdl/ifp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_queue: short record queue
// Register-based FIFO between the parser and the result builder so that
// each side stalls on its own.
// ----------------------------------------------------------------------------
module ifp_queue
    import ifp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ifp_rec_t rec_in,
    input  logic     pop,
    output logic     q_valid,
    output ifp_rec_t rec_out,
    output logic     q_full
);

    ifp_rec_t            ent_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign rec_out = ent_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= rec_in;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full && !pop))
        else $error("record pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("record popped from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue fill count out of range");

endmodule

// File: hdl/ifp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_back: result builder
// Two-stage pipeline: scaling products, then sums, sign, saturation and
// the output register.
// ----------------------------------------------------------------------------
module ifp_back
    import ifp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [14:0]        day_offset,
    input  logic               q_valid,
    input  ifp_rec_t           q_rec,
    output logic               pop,
    input  logic               out_stall,
    output logic               out_valid,
    output logic               is_fix,
    output logic [30:0]        timestamp,
    output logic signed [23:0] latitude,
    output logic signed [26:0] longitude,
    output logic signed [17:0] altitude
);

    // Stage 1 registers
    logic               s1_valid_reg;
    logic [31:0]        s1_day_reg;
    logic signed [19:0] s1_sod_reg;
    logic signed [23:0] s1_latd_reg;
    logic signed [26:0] s1_lond_reg;
    logic signed [17:0] s1_latm_reg;
    logic signed [17:0] s1_lonm_reg;
    logic signed [17:0] s1_alt_reg;
    logic               s1_fix_reg;
    logic               s1_north_reg;
    logic               s1_east_reg;
    logic               s1_altf_reg;

    // Output registers
    logic               out_valid_reg;
    logic               is_fix_reg;
    logic [30:0]        ts_reg;
    logic signed [23:0] lat_reg;
    logic signed [26:0] lon_reg;
    logic signed [17:0] alt_reg;

    logic               s1_load;
    logic               s2_load;
    logic [31:0]        day_next;
    logic signed [19:0] sod_next;
    logic signed [23:0] latd_next;
    logic signed [26:0] lond_next;
    logic signed [33:0] ts_sum;
    logic [30:0]        ts_next;
    logic signed [23:0] lat_sum;
    logic signed [26:0] lon_sum;
    logic signed [23:0] lat_next;
    logic signed [26:0] lon_next;
    logic signed [17:0] alt_next;

    // Pipeline advance
    assign s2_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_load = q_valid && (!s1_valid_reg || s2_load);
    assign pop     = s1_load;

    // Stage 1: constant-scale products
    always_comb
    begin
        day_next  = 32'(day_offset) * 32'(SECS_PER_DAY);
        sod_next  = '0;
        if (q_rec.fix)
            sod_next = 20'(q_rec.hours) * 20'(SECS_PER_HOUR)
                     + 20'(q_rec.minutes) * 20'(SECS_PER_MIN)
                     + 20'(q_rec.seconds);
        latd_next = 24'(q_rec.lat_deg) * 24'(UNITS_PER_DEG);
        lond_next = 27'(q_rec.lon_deg) * 27'(UNITS_PER_DEG);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= 1'b1;
        else if (s2_load)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_day_reg   <= day_next;
            s1_sod_reg   <= sod_next;
            s1_latd_reg  <= latd_next;
            s1_lond_reg  <= lond_next;
            s1_latm_reg  <= q_rec.lat_min;
            s1_lonm_reg  <= q_rec.lon_min;
            s1_alt_reg   <= q_rec.alt;
            s1_fix_reg   <= q_rec.fix;
            s1_north_reg <= q_rec.north;
            s1_east_reg  <= q_rec.east;
            s1_altf_reg  <= q_rec.alt_flag;
        end
    end

    // Stage 2: sums, hemisphere sign, timestamp saturation, zeroing for non-fix or no-altitude lines
    always_comb
    begin
        ts_sum  = $signed({2'b00, s1_day_reg}) + 34'(s1_sod_reg);
        if (ts_sum[33])
            ts_next = '0;
        else if (ts_sum[32:31] != 2'b00)
            ts_next = '1;
        else
            ts_next = ts_sum[30:0];
        lat_sum  = s1_latd_reg + 24'(s1_latm_reg);
        lon_sum  = s1_lond_reg + 27'(s1_lonm_reg);
        lat_next = '0;
        lon_next = '0;
        alt_next = '0;
        if (s1_fix_reg)
        begin
            lat_next = s1_north_reg ? lat_sum : -lat_sum;
            lon_next = s1_east_reg ? lon_sum : -lon_sum;
            if (s1_altf_reg)
                alt_next = s1_alt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            is_fix_reg <= s1_fix_reg;
            ts_reg     <= ts_next;
            lat_reg    <= lat_next;
            lon_reg    <= lon_next;
            alt_reg    <= alt_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_fix    = is_fix_reg;
    assign timestamp = ts_reg;
    assign latitude  = lat_reg;
    assign longitude = lon_reg;
    assign altitude  = alt_reg;

    // A line that is not a fix carries no position
    a_nonfix_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !is_fix_reg |-> (lat_reg == '0) && (lon_reg == '0)
                                         && (alt_reg == '0))
        else $error("non-fix result with nonzero position");

endmodule

// File: hdl/igc_fix_record_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igc_fix_record_parser_core: flight-log fix record parser
// Parses one ASCII line per result into time, position and altitude.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one byte per transfer, char_code
//   plus end_of_line on the last byte of the line. A byte is taken in every
//   cycle in which in_valid is high and in_stall is low.
//   Output channel (out_valid / out_stall): one result per line. The result
//   passes through the queue, the product stage and the output register in
//   turn. Results leave at up to one per cycle while out_stall is low,
//   limited by the byte parser, which pushes one record per line.
//   Configuration (cfg_valid / cfg_ready, data day_offset): always ready;
//   write only while no line is in flight.
//   Reset clears the byte position, all field accumulators, the two-entry
//   record queue, the pipeline and day_offset.
//   When out_stall is held, the output register holds its result, the
//   pipeline and queue fill, and then in_stall rises until results drain;
//   bytes of a line keep being taken while the queue has room.
// ----------------------------------------------------------------------------
module igc_fix_record_parser_core
    import ifp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_code,
    input  logic               end_of_line,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               is_fix,
    output logic [30:0]        timestamp,
    output logic signed [23:0] latitude,
    output logic signed [26:0] longitude,
    output logic signed [17:0] altitude,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [14:0]        day_offset
);

    logic [14:0] day_offset_reg;
    logic [14:0] day_offset_next;
    logic        push;
    logic        pop;
    logic        q_valid;
    logic        q_full;
    ifp_rec_t    rec_in;
    ifp_rec_t    rec_out;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_comb
    begin
        day_offset_next = day_offset_reg;
        if (cfg_valid && cfg_ready)
            day_offset_next = day_offset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            day_offset_reg <= '0;
        else
            day_offset_reg <= day_offset_next;
    end

    // Byte parser
    ifp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .char_code   (char_code),
        .end_of_line (end_of_line),
        .q_full      (q_full),
        .in_stall    (in_stall),
        .push        (push),
        .rec         (rec_in)
    );

    // Record queue
    ifp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rec_in  (rec_in),
        .pop     (pop),
        .q_valid (q_valid),
        .rec_out (rec_out),
        .q_full  (q_full)
    );

    // Result builder
    ifp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .day_offset (day_offset_reg),
        .q_valid    (q_valid),
        .q_rec      (rec_out),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .is_fix     (is_fix),
        .timestamp  (timestamp),
        .latitude   (latitude),
        .longitude  (longitude),
        .altitude   (altitude)
    );

endmodule
